[hdl/xsd_pkg.sv]
// Shared types, constants and helpers for the XOR sprite draw block.
package xsd_pkg;

  // Default screen geometry and fixed sprite width
  localparam int SCREEN_WIDTH_DEF  = 64;
  localparam int SCREEN_HEIGHT_DEF = 32;
  localparam int SPRITE_WIDTH      = 8;

  // Reduction steps: coordinates stay below 2^MOD_STEPS times the smallest screen side
  localparam int MOD_STEPS = 6;

  // One sprite row request
  typedef struct packed {
    logic [7:0] origin_x;
    logic [7:0] origin_y;
    logic [3:0] row_offset;
    logic [7:0] row_bits;
    logic       last_row;
  } in_t;

  // One result per row
  typedef struct packed {
    logic collision;
    logic sprite_done;
  } out_t;

  // Wrap a coordinate onto the screen by restoring reduction with shifted divisors
  function automatic logic [8:0] mod_reduce(input logic [8:0] val, input logic [8:0] divisor);
    logic [15:0] rem;
    logic [15:0] step;
    rem  = 16'(val);
    step = '0;
    for (int j = MOD_STEPS - 1; j >= 0; j--) begin
      step = 16'(divisor) << j;
      if (rem >= step) begin
        rem = rem - step;
      end
    end
    return rem[8:0];
  endfunction

endpackage

[hdl/xsd_row_prep.sv]
// Row address and pixel mask generation for one sprite row request.
module xsd_row_prep #(
  parameter int SCREEN_WIDTH  = xsd_pkg::SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = xsd_pkg::SCREEN_HEIGHT_DEF
) (
  input  xsd_pkg::in_t                         req,
  output logic [$clog2(SCREEN_HEIGHT)-1:0]     row,
  output logic [SCREEN_WIDTH-1:0]              mask
);
  import xsd_pkg::*;

  localparam int XW = $clog2(SCREEN_WIDTH);
  localparam int YW = $clog2(SCREEN_HEIGHT);
  localparam logic [8:0] WDIV = 9'(SCREEN_WIDTH);
  localparam logic [8:0] HDIV = 9'(SCREEN_HEIGHT);

  logic [8:0]  x_wrap;
  logic [8:0]  y_wrap;
  logic [XW:0] x_sum [SPRITE_WIDTH];
  logic [XW-1:0] px  [SPRITE_WIDTH];

  // Wrap origin and target row onto the screen
  always_comb begin
    x_wrap = mod_reduce({1'b0, req.origin_x}, WDIV);
    y_wrap = mod_reduce(9'(req.origin_y) + 9'(req.row_offset), HDIV);
    row    = y_wrap[YW-1:0];
  end

  // Place each sprite pixel on its wrapped column
  always_comb begin
    for (int k = 0; k < SPRITE_WIDTH; k++) begin
      x_sum[k] = (XW+1)'(x_wrap[XW-1:0]) + (XW+1)'(k);
      if (x_sum[k] >= (XW+1)'(SCREEN_WIDTH)) begin
        px[k] = XW'(x_sum[k] - (XW+1)'(SCREEN_WIDTH));
      end else begin
        px[k] = x_sum[k][XW-1:0];
      end
    end
  end

  // Build the toggle mask, MSB of the pattern leftmost
  always_comb begin
    mask = '0;
    for (int p = 0; p < SCREEN_WIDTH; p++) begin
      for (int k = 0; k < SPRITE_WIDTH; k++) begin
        if (req.row_bits[SPRITE_WIDTH-1-k] && (px[k] == XW'(p))) begin
          mask[p] = 1'b1;
        end
      end
    end
  end

endmodule

[hdl/xor_sprite_draw_collision_top.sv]
// XOR sprite row draw with collision flag over a one-bit frame buffer.
//
// Input channel (in_valid / in_stall / in_data) carries one sprite row per
// request: origin, row offset within the sprite, an 8-pixel pattern and a
// last-row mark. Each set pattern bit toggles one pixel, with both
// coordinates wrapping around the screen. A row offset of zero starts a
// sprite and clears the collision flag.
// Output channel (out_valid / out_stall / out_data) returns one result per
// row: the collision flag so far in the sprite and the echoed last-row mark.
// A request accepted into the modify stage has its result registered when
// that stage advances. One row is taken per cycle while out_stall is low:
// the frame buffer row is read at acceptance, modified and written back as
// the row advances, the last write forwarded to a following same-line row.
// Reset clears the whole frame buffer at once through per-line valid bits,
// plus the flag and the pipeline valid bits; no clearing pass is needed.
// When the receiver stalls, the result register and the row in flight hold
// and in_stall rises while a row is in flight; nothing is dropped.
module xor_sprite_draw_collision_top #(
  parameter int SCREEN_WIDTH  = xsd_pkg::SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = xsd_pkg::SCREEN_HEIGHT_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  xsd_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output xsd_pkg::out_t out_data
);
  import xsd_pkg::*;

  localparam int YW = $clog2(SCREEN_HEIGHT);

  // Frame buffer and per-line valid bits
  logic [SCREEN_WIDTH-1:0]  frame_mem [SCREEN_HEIGHT];
  logic [SCREEN_HEIGHT-1:0] row_valid;

  logic [YW-1:0]           prep_row;
  logic [SCREEN_WIDTH-1:0] prep_mask;
  logic                    accept;

  // Modify stage
  logic                    s1_valid;
  logic [YW-1:0]           s1_row;
  logic [SCREEN_WIDTH-1:0] s1_mask;
  logic                    s1_first;
  logic                    s1_last;
  logic [SCREEN_WIDTH-1:0] rd_data;
  logic                    s1_advance;

  // Last write, for forwarding
  logic                    fwd_valid;
  logic [YW-1:0]           fwd_row;
  logic [SCREEN_WIDTH-1:0] fwd_data;
  logic                    fwd_hit;

  logic [SCREEN_WIDTH-1:0] old_row;
  logic [SCREEN_WIDTH-1:0] row_data_next;
  logic                    hit_flag;
  logic                    hit_next;

  xsd_row_prep #(
    .SCREEN_WIDTH (SCREEN_WIDTH),
    .SCREEN_HEIGHT(SCREEN_HEIGHT)
  ) u_prep (
    .req (in_data),
    .row (prep_row),
    .mask(prep_mask)
  );

  // Handshake: the modify stage moves when the result register is free
  always_comb begin
    s1_advance = s1_valid && (!out_valid || !out_stall);
    in_stall   = s1_valid && !s1_advance;
    accept     = in_valid && !in_stall;
  end

  // Merge forwarded data, toggle pixels, update the flag
  always_comb begin
    fwd_hit = fwd_valid && (fwd_row == s1_row);
    if (fwd_hit) begin
      old_row = fwd_data;
    end else if (row_valid[s1_row]) begin
      old_row = rd_data;
    end else begin
      old_row = '0;
    end
    row_data_next = old_row ^ s1_mask;
    hit_next      = (s1_first ? 1'b0 : hit_flag) | (|(old_row & s1_mask));
  end

  // Read at acceptance, write back on advance
  always_ff @(posedge clk) begin
    if (accept) begin
      rd_data <= frame_mem[prep_row];
    end
    if (s1_advance) begin
      frame_mem[s1_row] <= row_data_next;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
      fwd_valid <= 1'b0;
      row_valid <= '0;
      hit_flag  <= 1'b0;
    end else begin
      if (!s1_valid || s1_advance) begin
        s1_valid <= accept;
      end
      if (s1_advance) begin
        out_valid          <= 1'b1;
        fwd_valid          <= 1'b1;
        row_valid[s1_row]  <= 1'b1;
        hit_flag           <= hit_next;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_row   <= prep_row;
      s1_mask  <= prep_mask;
      s1_first <= (in_data.row_offset == 4'd0);
      s1_last  <= in_data.last_row;
    end
    if (s1_advance) begin
      fwd_row              <= s1_row;
      fwd_data             <= row_data_next;
      out_data.collision   <= hit_next;
      out_data.sprite_done <= s1_last;
    end
  end

`ifndef SYNTHESIS
  // A written line reads as valid from then on
  a_line_valid: assert property (@(posedge clk) disable iff (rst)
    s1_advance |=> row_valid[$past(s1_row)])
    else $error("written frame line not marked valid");

  // Forwarded data only ever stands for a line already written
  a_fwd_written: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && fwd_hit) |-> row_valid[s1_row])
    else $error("forward hit on a line never written");

  // A first row without any erased pixel leaves the flag clear
  a_first_clear: assert property (@(posedge clk) disable iff (rst)
    (s1_advance && s1_first && !(|(old_row & s1_mask))) |=> !hit_flag)
    else $error("collision flag survived a sprite start");

  // A stalled result blocks a full modify stage from moving
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall && s1_valid) |=> (s1_valid && $stable(s1_row)))
    else $error("row in flight lost under output stall");
`endif

endmodule
